>>> rtl/core/yrsp_pkg.sv
// Package for the YUV 4:2:2 to RGB888 stream packer.
// Holds coefficients, the queue entry type, queue status and channel saturation.
// No dependencies.
`default_nettype none

package yrsp_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic signed [8:0]  CHROMA_OFFSET = 9'sd128;
    localparam logic signed [19:0] COEF_RV = 20'sd1436;
    localparam logic signed [19:0] COEF_GU = 20'sd352;
    localparam logic signed [19:0] COEF_GV = 20'sd731;
    localparam logic signed [19:0] COEF_BU = 20'sd1814;
    localparam int unsigned        FRAC_BITS = 10;
    localparam logic [7:0]         CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [47:0] pix_bytes;
        logic        last;
    } yrsp_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } yrsp_qstat_t;

    function automatic logic [7:0] sat8(input logic signed [10:0] x);
        logic [7:0] res;
        if (x[10])
        begin
            res = 8'd0;
        end
        else if (x[9:8] != 2'b00)
        begin
            res = CHAN_MAX;
        end
        else
        begin
            res = x[7:0];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

>>> rtl/core/yrsp_if.sv
// Stream channel interfaces for the YUV to RGB packer.
// Input beat carries a YUV word, output beat an RGB word. No dependencies.
`default_nettype none

interface yrsp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] yuv_word;
    logic        last_word;

    modport source (output valid, output yuv_word, output last_word, input ready);
    modport sink (input valid, input yuv_word, input last_word, output ready);
endinterface

interface yrsp_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] rgb_word;
    logic        last_out;

    modport source (output valid, output rgb_word, output last_out, input ready);
    modport sink (input valid, input rgb_word, input last_out, output ready);
endinterface

`default_nettype wire

>>> rtl/core/yrsp_front.sv
// Front end: accepts YUV beats, converts each to six RGB bytes over two stages.
// Depends on yrsp_pkg and yrsp_in_if.
`default_nettype none

module yrsp_front (
    input  wire logic           clk,
    input  wire logic           rst_n,
    yrsp_in_if.sink             pix_in,
    input  yrsp_pkg::yrsp_qstat_t q_stat,
    output logic                push,
    output yrsp_pkg::yrsp_entry_t push_entry
);
    import yrsp_pkg::*;

    logic              s1_valid_reg;
    logic              s1_valid_next;
    logic [7:0]        y0_reg;
    logic [7:0]        y1_reg;
    logic signed [9:0] rt_reg;
    logic signed [9:0] gu_reg;
    logic signed [9:0] gv_reg;
    logic signed [9:0] bt_reg;
    logic              last_reg;

    logic              advance;
    logic              accept;
    logic signed [8:0] du;
    logic signed [8:0] dv;
    logic signed [19:0] prod_rv;
    logic signed [19:0] prod_gu;
    logic signed [19:0] prod_gv;
    logic signed [19:0] prod_bu;
    logic signed [9:0] gt;
    logic signed [10:0] y0_ext;
    logic signed [10:0] y1_ext;

    assign advance      = !s1_valid_reg || !q_stat.full;
    assign pix_in.ready = advance;
    assign accept       = pix_in.valid && advance;
    assign push         = s1_valid_reg && !q_stat.full;

    assign du = $signed({1'b0, pix_in.yuv_word[15:8]}) - CHROMA_OFFSET;
    assign dv = $signed({1'b0, pix_in.yuv_word[31:24]}) - CHROMA_OFFSET;

    assign prod_rv = COEF_RV * 20'(dv);
    assign prod_gu = COEF_GU * 20'(du);
    assign prod_gv = COEF_GV * 20'(dv);
    assign prod_bu = COEF_BU * 20'(du);

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (advance)
        begin
            s1_valid_next = pix_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    // floor shift: keep the upper bits of each product
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            y0_reg   <= pix_in.yuv_word[7:0];
            y1_reg   <= pix_in.yuv_word[23:16];
            rt_reg   <= prod_rv[19:FRAC_BITS];
            gu_reg   <= prod_gu[19:FRAC_BITS];
            gv_reg   <= prod_gv[19:FRAC_BITS];
            bt_reg   <= prod_bu[19:FRAC_BITS];
            last_reg <= pix_in.last_word;
        end
    end

    assign gt     = gu_reg + gv_reg;
    assign y0_ext = $signed({3'b000, y0_reg});
    assign y1_ext = $signed({3'b000, y1_reg});

    always_comb
    begin
        push_entry.pix_bytes[7:0]   = sat8(y0_ext + 11'(rt_reg));
        push_entry.pix_bytes[15:8]  = sat8(y0_ext - 11'(gt));
        push_entry.pix_bytes[23:16] = sat8(y0_ext + 11'(bt_reg));
        push_entry.pix_bytes[31:24] = sat8(y1_ext + 11'(rt_reg));
        push_entry.pix_bytes[39:32] = sat8(y1_ext - 11'(gt));
        push_entry.pix_bytes[47:40] = sat8(y1_ext + 11'(bt_reg));
        push_entry.last             = last_reg;
    end

endmodule

`default_nettype wire

>>> rtl/core/yrsp_queue.sv
// Short queue of converted pixel pairs between front end and packer.
// Depends on yrsp_pkg.
`default_nettype none

module yrsp_queue #(
    parameter int unsigned DEPTH = yrsp_pkg::QUEUE_DEPTH
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  yrsp_pkg::yrsp_entry_t push_entry,
    input  wire logic             pop,
    output yrsp_pkg::yrsp_entry_t head_entry,
    output yrsp_pkg::yrsp_qstat_t q_stat
);
    import yrsp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    yrsp_entry_t   mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        logic [PW-1:0] r;
        if (p == PW'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign q_stat.empty = (count_reg == '0);
    assign q_stat.full  = (count_reg == CW'(DEPTH));
    assign head_entry   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wrap_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? wrap_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !q_stat.empty)
        else $error("queue popped while empty");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (!q_stat.full || pop))
        else $error("queue pushed while full");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count out of range");

endmodule

`default_nettype wire

>>> rtl/core/yrsp_back.sv
// Back end: packs RGB bytes of queued pixel pairs into 32-bit output beats.
// Depends on yrsp_pkg and yrsp_out_if.
`default_nettype none

module yrsp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  yrsp_pkg::yrsp_entry_t head_entry,
    input  yrsp_pkg::yrsp_qstat_t q_stat,
    output logic                  pop,
    yrsp_out_if.source            pix_out
);
    import yrsp_pkg::*;

    logic        out_valid_reg;
    logic        out_valid_next;
    logic [31:0] out_word_reg;
    logic [31:0] out_word_next;
    logic        out_last_reg;
    logic        out_last_next;
    logic        held_valid_reg;
    logic        held_valid_next;
    logic [15:0] held_bytes_reg;
    logic [15:0] held_bytes_next;
    logic        sub_reg;
    logic        sub_next;
    logic        load;

    assign load = (!out_valid_reg || pix_out.ready) && !q_stat.empty;

    always_comb
    begin
        out_valid_next  = out_valid_reg && !pix_out.ready;
        out_word_next   = out_word_reg;
        out_last_next   = out_last_reg;
        held_valid_next = held_valid_reg;
        held_bytes_next = held_bytes_reg;
        sub_next        = sub_reg;
        pop             = 1'b0;
        if (load)
        begin
            out_valid_next = 1'b1;
            if (!held_valid_reg)
            begin
                if (!sub_reg)
                begin
                    out_word_next = head_entry.pix_bytes[31:0];
                    out_last_next = 1'b0;
                    if (head_entry.last)
                    begin
                        sub_next = 1'b1;
                    end
                    else
                    begin
                        held_valid_next = 1'b1;
                        held_bytes_next = head_entry.pix_bytes[47:32];
                        pop             = 1'b1;
                    end
                end
                else
                begin
                    // flush the two trailing bytes, zero padded
                    out_word_next = {16'h0000, head_entry.pix_bytes[47:32]};
                    out_last_next = 1'b1;
                    sub_next      = 1'b0;
                    pop           = 1'b1;
                end
            end
            else
            begin
                if (!sub_reg)
                begin
                    out_word_next = {head_entry.pix_bytes[15:0], held_bytes_reg};
                    out_last_next = 1'b0;
                    sub_next      = 1'b1;
                end
                else
                begin
                    out_word_next   = head_entry.pix_bytes[47:16];
                    out_last_next   = head_entry.last;
                    held_valid_next = 1'b0;
                    held_bytes_next = 16'h0000;
                    sub_next        = 1'b0;
                    pop             = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            held_valid_reg <= 1'b0;
            held_bytes_reg <= 16'h0000;
            sub_reg        <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            held_valid_reg <= held_valid_next;
            held_bytes_reg <= held_bytes_next;
            sub_reg        <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_word_reg <= out_word_next;
        out_last_reg <= out_last_next;
    end

    assign pix_out.valid    = out_valid_reg;
    assign pix_out.rgb_word = out_word_reg;
    assign pix_out.last_out = out_last_reg;

    a_last_clears_held: assert property (@(posedge clk) disable iff (!rst_n)
        (load && out_last_next) |=> (!held_valid_reg && !sub_reg))
        else $error("bytes still held after last beat");

    a_sub_has_entry: assert property (@(posedge clk) disable iff (!rst_n)
        sub_reg |-> !q_stat.empty)
        else $error("second beat pending without queued entry");

    a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> load)
        else $error("entry dropped without an output beat");

endmodule

`default_nettype wire

>>> rtl/core/yuv422_rgb_stream_packer.sv
// YUV 4:2:2 to RGB888 stream packer, top level.
// pix_in (sink) takes one YUV word per beat: Y0 7:0, U 15:8, Y1 23:16, V 31:24,
// plus last_word. pix_out (source) gives 32-bit RGB beats, earliest byte in 7:0,
// bytes in R,G,B order, last_out on the final beat of a frame.
// Two input beats give three output beats; a frame ending on a half-filled
// word gets a zero-padded flush beat with last_out set.
// A taken input beat passes the product register, then the queue write, then
// the output register. Throughput: one output beat per cycle while pix_out.ready
// is high and the queue is not empty, set by the single output register; input
// sustains two beats per three output beats, and a beat may enter every cycle
// until the queue (QUEUE_DEPTH pixel pairs) fills.
// Reset clears the held bytes, the queue and all valid flags; no beat is shown.
// When the receiver stalls, the output beat holds, the queue fills, and then
// pix_in.ready drops.
// Depends on yrsp_pkg, yrsp_if, yrsp_front, yrsp_queue and yrsp_back.
`default_nettype none

module yuv422_rgb_stream_packer #(
    parameter int unsigned QUEUE_DEPTH = yrsp_pkg::QUEUE_DEPTH
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    yrsp_in_if.sink    pix_in,
    yrsp_out_if.source pix_out
);
    import yrsp_pkg::*;

    logic        push;
    logic        pop;
    yrsp_entry_t push_entry;
    yrsp_entry_t head_entry;
    yrsp_qstat_t q_stat;

    yrsp_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .pix_in     (pix_in),
        .q_stat     (q_stat),
        .push       (push),
        .push_entry (push_entry)
    );

    yrsp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .q_stat     (q_stat)
    );

    yrsp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_entry (head_entry),
        .q_stat     (q_stat),
        .pop        (pop),
        .pix_out    (pix_out)
    );

endmodule

`default_nettype wire
